// ===== rtl/mexp_pkg.sv =====
// shared widths and register indexes for the modular exponentiation unit
package mexp_pkg;
   localparam int KeyBits = 32;
   localparam int CntBits = $clog2(KeyBits);
   localparam int CsrIdxBits = 1;
   localparam logic [CsrIdxBits-1:0] CsrModulus = 1'b0;
   localparam logic [CsrIdxBits-1:0] CsrExponent = 1'b1;
endpackage

// ===== rtl/modular_exponentiation_unit.sv =====
// modular exponentiation unit: square-and-multiply with a bit-serial modular multiplier
//
//  channel | ports                                                      | direction
//  req     | req_valid, req_ready, req_base_value                       | in
//  rsp     | rsp_valid, rsp_ready, rsp_power_result, rsp_modulus_error  | out
//  csr     | csr_write, csr_index, csr_data                             | in
//
// the base is reduced by one shift-subtract pass, then each exponent bit costs
// a square and, if set, a multiply (one doubling and one add per cycle)
// zero modulus or zero exponent goes straight from IDLE to DONE
// one word at a time; the result register holds while rsp_ready is low
// reset is synchronous and clears the control state and the two registers
module modular_exponentiation_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [mexp_pkg::KeyBits-1:0] req_base_value,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [mexp_pkg::KeyBits-1:0] rsp_power_result,
   output logic rsp_modulus_error,
   input  logic csr_write,
   input  logic [mexp_pkg::CsrIdxBits-1:0] csr_index,
   input  logic [mexp_pkg::KeyBits-1:0] csr_data
);
   localparam int W = mexp_pkg::KeyBits;
   localparam int C = mexp_pkg::CntBits;

   typedef enum logic [2:0] {IDLE, REDUCE, SQUARE, MULT, DONE} state_type;

   state_type state_ff;
   logic [W-1:0] mod_ff, exp_ff;
   logic [W-1:0] base_ff, acc_ff, prod_ff, mplr_ff, rem_ff, res_ff;
   logic [C-1:0] bit_ff, ebit_ff;
   logic err_ff, valid_ff;

   // (a+b) mod n with a,b < n
   function automatic logic [W-1:0] add_mod(logic [W-1:0] a, logic [W-1:0] b,
                                            logic [W-1:0] n);
      logic [W-1:0] room;
      room = n - b;
      return (a >= room) ? (a - room) : (a + b);
   endfunction

   logic [W-1:0] dbl_in, step_in, rem_in, mand;
   logic [W:0] rem_sh;

   always_comb begin
      mand = (state_ff == SQUARE) ? acc_ff : base_ff;
      dbl_in = add_mod(prod_ff, prod_ff, mod_ff);
      step_in = mplr_ff[W-1] ? add_mod(dbl_in, mand, mod_ff) : dbl_in;
      rem_sh = {rem_ff, base_ff[W-1]};
      rem_in = (rem_sh >= {1'b0, mod_ff}) ? W'(rem_sh - {1'b0, mod_ff}) : rem_sh[W-1:0];
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_power_result = res_ff;
   assign rsp_modulus_error = err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= 1'b0;
         mod_ff <= '0;
         exp_ff <= '0;
      end else begin
         if (csr_write && csr_index == mexp_pkg::CsrModulus) mod_ff <= csr_data;
         if (csr_write && csr_index == mexp_pkg::CsrExponent) exp_ff <= csr_data;
         case (state_ff)
            IDLE: begin
               if (req_valid) begin
                  base_ff <= req_base_value;
                  rem_ff <= '0;
                  bit_ff <= C'(W - 1);
                  if (mod_ff == '0) begin
                     res_ff <= '0;
                     err_ff <= 1'b1;
                     valid_ff <= 1'b1;
                     state_ff <= DONE;
                  end else if (exp_ff == '0) begin
                     res_ff <= W'(1);
                     err_ff <= 1'b0;
                     valid_ff <= 1'b1;
                     state_ff <= DONE;
                  end else begin
                     state_ff <= REDUCE;
                  end
               end
            end
            REDUCE: begin
               if (bit_ff == '0) begin
                  base_ff <= rem_in;
                  acc_ff <= (mod_ff == W'(1)) ? '0 : W'(1);
                  ebit_ff <= C'(W - 1);
                  prod_ff <= '0;
                  mplr_ff <= (mod_ff == W'(1)) ? '0 : W'(1);
                  bit_ff <= C'(W - 1);
                  state_ff <= SQUARE;
               end else begin
                  rem_ff <= rem_in;
                  base_ff <= base_ff << 1;
                  bit_ff <= bit_ff - 1'b1;
               end
            end
            SQUARE, MULT: begin
               if (bit_ff == '0) begin
                  prod_ff <= '0;
                  bit_ff <= C'(W - 1);
                  if (state_ff == SQUARE && exp_ff[ebit_ff]) begin
                     acc_ff <= step_in;
                     mplr_ff <= step_in;
                     state_ff <= MULT;
                  end else if (ebit_ff == '0) begin
                     res_ff <= step_in;
                     err_ff <= 1'b0;
                     valid_ff <= 1'b1;
                     state_ff <= DONE;
                  end else begin
                     acc_ff <= step_in;
                     mplr_ff <= step_in;
                     ebit_ff <= ebit_ff - 1'b1;
                     state_ff <= SQUARE;
                  end
               end else begin
                  prod_ff <= step_in;
                  mplr_ff <= mplr_ff << 1;
                  bit_ff <= bit_ff - 1'b1;
               end
            end
            DONE: begin
               if (rsp_ready) begin
                  valid_ff <= 1'b0;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule

// ===== dv/testbench.sv =====
// testbench for the modular exponentiation unit: random and directed words checked against a power-mod predictor
`timescale 1ns / 1ps

class power_scoreboard;
   logic [31:0] modulus;
   logic [31:0] exponent;
   logic [32:0] pending_result[$];
   int errors;

   function new();
      modulus = '0;
      exponent = '0;
      errors = 0;
   endfunction

   function logic [31:0] mul_mod(logic [31:0] a, logic [31:0] b, logic [31:0] n);
      logic [63:0] prod;
      prod = {32'd0, a} * {32'd0, b};
      return 32'(prod % {32'd0, n});
   endfunction

   function logic [32:0] power_of(logic [31:0] base);
      logic [31:0] acc;
      logic [31:0] b;
      if (modulus == 0) return {1'b1, 32'd0};
      if (exponent == 0) return {1'b0, 32'd1};
      b = base % modulus;
      acc = 32'd1 % modulus;
      for (int i = 31; i >= 0; i--) begin
         acc = mul_mod(acc, acc, modulus);
         if (exponent[i]) acc = mul_mod(acc, b, modulus);
      end
      return {1'b0, acc};
   endfunction

   function void note_word(logic [31:0] base);
      pending_result.push_back(power_of(base));
   endfunction

   function void check_word(logic [31:0] value, logic err);
      logic [32:0] want;
      if (pending_result.size() == 0) begin
         report("result word with nothing pending");
         return;
      end
      want = pending_result.pop_front();
      if (value !== want[31:0]) report($sformatf("power_result %h, want %h", value, want[31:0]));
      if (err !== want[32]) report($sformatf("modulus_error %b, want %b", err, want[32]));
   endfunction

   function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endfunction
endclass

module testbench;
   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [mexp_pkg::KeyBits-1:0] req_base_value = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [mexp_pkg::KeyBits-1:0] rsp_power_result;
   logic rsp_modulus_error;
   logic csr_write = 0;
   logic [mexp_pkg::CsrIdxBits-1:0] csr_index = mexp_pkg::CsrModulus;
   logic [mexp_pkg::KeyBits-1:0] csr_data = '0;
   logic stimulus_done = 0;
   int idle_cycles = 0;
   power_scoreboard board = new();

   modular_exponentiation_unit dut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   function int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(20, 3000);
   endfunction

   // leaves csr_write high; the caller drops it once
   task automatic write_reg(logic [mexp_pkg::CsrIdxBits-1:0] idx, logic [31:0] value);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      if (idx == mexp_pkg::CsrModulus) board.modulus = value;
      else board.exponent = value;
   endtask

   // leaves req_valid high after the accepting edge; the next gap or drain drops it
   task automatic send_word(logic [31:0] base);
      int g;
      g = gap_length();
      if (g != 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_base_value <= base;
      do @(posedge clock); while (!req_ready);
      board.note_word(base);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending_result.size() != 0) @(posedge clock);
      repeat (2500) @(posedge clock);
   endtask

   task automatic set_key(logic [31:0] n, logic [31:0] e);
      drain();
      write_reg(mexp_pkg::CsrModulus, n);
      write_reg(mexp_pkg::CsrExponent, e);
      csr_write <= 0;
   endtask

   function logic [31:0] rand_base();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return board.modulus;
         default: return $urandom();
      endcase
   endfunction

   function logic [31:0] rand_modulus();
      case ($urandom_range(0, 7))
         0: return 32'd1;
         1: return 32'hFFFF_FFFF;
         2: return 32'd2;
         3: return 32'd0;
         default: return $urandom() | 32'h1;
      endcase
   endfunction

   function logic [31:0] rand_exponent();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'd1;
         default: return $urandom();
      endcase
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_word(rsp_power_result, rsp_modulus_error);
         rsp_ready <= (gap_length() == 0) || ($urandom_range(0, 1) == 1);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || stimulus_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: reset registers give a zero modulus
      send_word(32'h1234_5678);
      set_key(32'd0, 32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFF);
      set_key(32'd1, 32'd0);
      send_word(32'd5);
      set_key(32'd13, 32'd0);
      send_word(32'd0);
      set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFF);
      send_word(32'hFFFF_FFFE);
      send_word(32'd0);
      send_word(32'hAAAA_5555);
      set_key(32'd3233, 32'd17);
      send_word(32'd65);
      send_word(32'd3233);
      send_word(32'd4000);
      set_key(32'd3233, 32'd2753);
      send_word(32'd2790);
      set_key(32'h8000_0000, 32'd1);
      send_word(32'hFFFF_FFFF);
      set_key(32'd1, 32'h5555_5555);
      send_word(32'h5555_5555);
      // random phases; each key set also drains, so the sender waits for all results
      for (int p = 0; p < 25; p++) begin
         set_key(rand_modulus(), rand_exponent());
         for (int i = 0; i < 10; i++) send_word(rand_base());
      end
      drain();
      stimulus_done <= 1;
      if (board.errors == 0 && board.pending_result.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
